// File: design/rotation_matrix_to_euler_angles_unit_defines.svh
// Assertion macros shared by the rotation matrix to Euler angles design.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RME_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RME_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/rme_pkg.sv
// Package with constants, the arctangent table and helpers for the Euler angle unit.
`default_nettype none
package rme_pkg;
  localparam int unsigned CordicIterationsDefault = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned DataW = 28;
  localparam int unsigned AccW = 26;
  localparam int unsigned ThrW = 15;
  localparam logic [ThrW-1:0] ThresholdReset = 15'd1;
  localparam logic signed [AccW-1:0] Deg90 = 26'sd5898240;
  localparam logic [15:0] GainComp = 16'd39797;
  localparam logic signed [AccW-1:0] LimXz = 26'sd23040;
  localparam logic signed [AccW-1:0] LimY = 26'sd11520;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [AccW-1:0] acc_t;

  function automatic acc_t atan_entry(input logic [4:0] idx);
    acc_t r;
    case (idx)
      5'd0: r = 26'sd2949120;
      5'd1: r = 26'sd1740967;
      5'd2: r = 26'sd919879;
      5'd3: r = 26'sd466945;
      5'd4: r = 26'sd234379;
      5'd5: r = 26'sd117304;
      5'd6: r = 26'sd58666;
      5'd7: r = 26'sd29335;
      5'd8: r = 26'sd14668;
      5'd9: r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic acc_t to_out(input acc_t acc, input acc_t lim);
    acc_t v;
    v = (acc + acc_t'(256)) >>> 9;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction
endpackage
`default_nettype wire

// File: design/rotation_matrix_to_euler_angles_unit.sv
// Top level: ZYX Euler angles from a Q1.14 rotation matrix through pipelined CORDIC units.
// Path from accepted start to out_strobe: z CORDIC, gain stage, decide stage, y and x CORDIC, output register.
// Throughput: one word per cycle; busy stays low, set by the fully pipelined CORDIC stages.
// Reset (rst_n low, synchronous) empties the pipeline and sets the threshold to 1.
// The receiver cannot stall; each result shows for one cycle with out_strobe.
`default_nettype none
`include "rotation_matrix_to_euler_angles_unit_defines.svh"
module rotation_matrix_to_euler_angles_unit #(
  parameter int unsigned CORDIC_ITERATIONS = rme_pkg::CordicIterationsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_m00,
  input  wire logic signed [15:0] in_m10,
  input  wire logic signed [15:0] in_m20,
  input  wire logic signed [15:0] in_m21,
  input  wire logic signed [15:0] in_m22,
  input  wire logic signed [15:0] in_m11,
  input  wire logic signed [15:0] in_m12,
  input  wire logic               cfg_we,
  input  wire logic [14:0]        cfg_wdata,
  output logic                    out_strobe,
  output logic signed [15:0]      out_angle_x,
  output logic signed [14:0]      out_angle_y,
  output logic signed [15:0]      out_angle_z,
  output logic                    out_singular
);
  localparam int unsigned Steps = (CORDIC_ITERATIONS < rme_pkg::AtanEntries) ?
                                  CORDIC_ITERATIONS : rme_pkg::AtanEntries;
  localparam int unsigned D1 = Steps + 2;

  function automatic rme_pkg::data_t widen(input logic signed [15:0] v);
    return rme_pkg::data_t'(v) <<< 8;
  endfunction

  logic [14:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= rme_pkg::ThresholdReset;
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  assign busy = 1'b0;

  // First pass: magnitude and z angle; the other operands ride along.
  logic           z_vld;
  rme_pkg::data_t z_mag;
  rme_pkg::acc_t  z_ang;
  rme_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_z (
    .clk, .rst_n, .in_vld(start), .in_x(widen(in_m00)), .in_y(widen(in_m10)),
    .out_vld(z_vld), .out_mag(z_mag), .out_ang(z_ang));

  logic signed [15:0] m20_d [D1];
  logic signed [15:0] m21_d [D1];
  logic signed [15:0] m22_d [D1];
  logic signed [15:0] m11_d [D1];
  logic signed [15:0] m12_d [D1];
  always_ff @(posedge clk) begin
    m20_d[0] <= in_m20; m21_d[0] <= in_m21; m22_d[0] <= in_m22;
    m11_d[0] <= in_m11; m12_d[0] <= in_m12;
    for (int k = 1; k < D1; k++) begin
      m20_d[k] <= m20_d[k-1]; m21_d[k] <= m21_d[k-1]; m22_d[k] <= m22_d[k-1];
      m11_d[k] <= m11_d[k-1]; m12_d[k] <= m12_d[k-1];
    end
  end

  // Zero vector gives zero magnitude and angle; CORDIC does not reach it alone.
  logic [Steps:0] zero_d;
  always_ff @(posedge clk) begin
    zero_d <= {zero_d[Steps-1:0], (in_m00 == '0) && (in_m10 == '0)};
  end

  // Gain stage: one multiply.
  logic           g_vld_r;
  logic [43:0]    g_prod_r;
  rme_pkg::acc_t  g_az_r;
  logic [26:0]    g_mag_c;
  always_comb begin
    g_mag_c = (z_mag < 0 || zero_d[Steps]) ? '0 : z_mag[26:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else g_vld_r <= z_vld;
    g_prod_r <= 44'(g_mag_c) * 44'(rme_pkg::GainComp) + 44'd32768;
    g_az_r <= zero_d[Steps] ? '0 : z_ang;
  end

  // Decide stage: threshold test and operand selection.
  logic           s_vld_r;
  logic           s_sing_r;
  rme_pkg::acc_t  s_az_r;
  rme_pkg::data_t s_sy_r, s_y2_r, s_x3_r, s_y3_r;
  logic [27:0]    sy_c;
  logic [19:0]    sy14_c;
  logic           sing_c;
  always_comb begin
    sy_c = g_prod_r[43:16];
    sy14_c = 20'((sy_c + 28'd128) >> 8);
    sing_c = sy14_c < 20'(thr_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s_vld_r <= 1'b0;
    else s_vld_r <= g_vld_r;
    s_sing_r <= sing_c;
    s_az_r <= g_az_r;
    s_sy_r <= rme_pkg::data_t'(sy_c);
    s_y2_r <= -widen(m20_d[D1-1]);
    s_x3_r <= sing_c ? widen(m11_d[D1-1]) : widen(m22_d[D1-1]);
    s_y3_r <= sing_c ? -widen(m12_d[D1-1]) : widen(m21_d[D1-1]);
  end

  logic           y_vld, x_vld;
  rme_pkg::data_t y_mag, x_mag;
  rme_pkg::acc_t  y_ang, x_ang;
  rme_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_y (
    .clk, .rst_n, .in_vld(s_vld_r), .in_x(s_sy_r), .in_y(s_y2_r),
    .out_vld(y_vld), .out_mag(y_mag), .out_ang(y_ang));
  rme_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_x (
    .clk, .rst_n, .in_vld(s_vld_r), .in_x(s_x3_r), .in_y(s_y3_r),
    .out_vld(x_vld), .out_mag(x_mag), .out_ang(x_ang));

  logic [Steps:0] sing_d;
  logic [Steps:0] yz_d;
  logic [Steps:0] xz_d;
  rme_pkg::acc_t  az_d [Steps+1];
  always_ff @(posedge clk) begin
    sing_d <= {sing_d[Steps-1:0], s_sing_r};
    yz_d <= {yz_d[Steps-1:0], (s_sy_r == '0) && (s_y2_r == '0)};
    xz_d <= {xz_d[Steps-1:0], (s_x3_r == '0) && (s_y3_r == '0)};
    az_d[0] <= s_az_r;
    for (int k = 1; k <= Steps; k++) az_d[k] <= az_d[k-1];
  end

  rme_pkg::acc_t ox_c, oy_c, oz_c;
  always_comb begin
    ox_c = rme_pkg::to_out(xz_d[Steps] ? '0 : x_ang, rme_pkg::LimXz);
    oy_c = rme_pkg::to_out(yz_d[Steps] ? '0 : y_ang, rme_pkg::LimY);
    oz_c = sing_d[Steps] ? '0 : rme_pkg::to_out(az_d[Steps], rme_pkg::LimXz);
  end

  logic out_strobe_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else out_strobe_r <= y_vld;
    out_angle_x <= ox_c[15:0];
    out_angle_y <= oy_c[14:0];
    out_angle_z <= oz_c[15:0];
    out_singular <= sing_d[Steps];
  end
  assign out_strobe = out_strobe_r;

  logic unused_mag;
  assign unused_mag = ^{y_mag, x_mag, x_vld};

  `RME_ASSERT_IMPL(a_lanes_aligned, clk, rst_n, 1'b1, y_vld == x_vld,
    "Angle lanes out of step.")
  `RME_ASSERT_NEXT(a_strobe_follows, clk, rst_n, y_vld, out_strobe,
    "Finished word lost.")
  `RME_ASSERT_IMPL(a_sing_z_zero, clk, rst_n, out_strobe && out_singular,
    out_angle_z == '0, "Singular word with nonzero z angle.")
  `RME_ASSERT_IMPL(a_y_range, clk, rst_n, out_strobe,
    out_angle_y <= 15'sd11520 && out_angle_y >= -15'sd11520, "y angle out of range.")
endmodule
`default_nettype wire

// File: design/rme_cordic.sv
// Pipelined vectoring CORDIC giving the angle in 2^-16 degree and the scaled magnitude.
`default_nettype none
module rme_cordic #(
  parameter int unsigned ITERATIONS = rme_pkg::CordicIterationsDefault
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire rme_pkg::data_t in_x,
  input  wire rme_pkg::data_t in_y,
  output logic                out_vld,
  output rme_pkg::data_t      out_mag,
  output rme_pkg::acc_t       out_ang
);
  localparam int unsigned Steps = (ITERATIONS < rme_pkg::AtanEntries) ?
                                  ITERATIONS : rme_pkg::AtanEntries;

  logic           vld_r [Steps+1];
  rme_pkg::data_t x_r   [Steps+1];
  rme_pkg::data_t y_r   [Steps+1];
  rme_pkg::acc_t  acc_r [Steps+1];
  rme_pkg::data_t x0_nxt, y0_nxt;
  rme_pkg::acc_t  acc0_nxt;

  always_comb begin
    x0_nxt = in_x;
    y0_nxt = in_y;
    acc0_nxt = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0_nxt = in_y;
        y0_nxt = -in_x;
        acc0_nxt = rme_pkg::Deg90;
      end else begin
        x0_nxt = -in_y;
        y0_nxt = in_x;
        acc0_nxt = -rme_pkg::Deg90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    x_r[0] <= x0_nxt;
    y_r[0] <= y0_nxt;
    acc_r[0] <= acc0_nxt;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        acc_r[i+1] <= acc_r[i] + rme_pkg::atan_entry(5'(i));
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        acc_r[i+1] <= acc_r[i] - rme_pkg::atan_entry(5'(i));
      end
    end
  end

  assign out_vld = vld_r[Steps];
  assign out_mag = x_r[Steps];
  assign out_ang = acc_r[Steps];
endmodule
`default_nettype wire
